[hw/rtl/binary_grid_autocorrelation_unit_macros.svh]
// Assertion macros of the grid autocorrelation unit.
`ifndef BINARY_GRID_AUTOCORRELATION_UNIT_MACROS_SVH
`define BINARY_GRID_AUTOCORRELATION_UNIT_MACROS_SVH

// Condition implies expression in the same cycle.
`define BGAC_ASSERT_IMP(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("bgac check failed");

// Condition implies expression in the next cycle.
`define BGAC_ASSERT_NXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("bgac check failed");

`endif

[hw/rtl/bgac_pkg.sv]
// Shared types and constants of the grid autocorrelation unit.
package bgac_pkg;

   // Field widths of the words on the channels.
   localparam int OPCODE_W   = 2;
   localparam int ROW_IDX_W  = 6;
   localparam int COL_IDX_W  = 8;
   localparam int DIST_W     = 8;
   localparam int SUM_OUT_W  = 10;

   // Saturation limits of the result sum.
   localparam int SUM_MAX = 511;
   localparam int SUM_MIN = -512;

   // Operation codes.
   localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_VERT  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_HORZ  = 2'd2;

   // Configuration port.
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam int HEIGHT_W = 7;
   localparam int WIDTH_W  = 9;
   localparam logic REG_GRID_HEIGHT = 1'b0;
   localparam logic REG_GRID_WIDTH  = 1'b1;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd64;
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 9'd256;

   // Cells compared per pass of the match counter.
   localparam int CHUNK_W   = 8;
   localparam int CHUNK_LOG = 3;

   // Control of the shared match counter.
   typedef struct packed {
      logic clear;
      logic add;
   } bgac_acc_ctrl_type;

endpackage

[hw/rtl/bgac_req_if.sv]
// Request channel interface: one command word per handshake.
interface bgac_req_if
   import bgac_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [ROW_IDX_W-1:0] row_index;
   logic [COL_IDX_W-1:0] column_index;
   logic                 cell_on;
   logic [DIST_W-1:0]    distance;

   modport source (output valid, opcode, row_index, column_index, cell_on, distance,
                   input ready);
   modport sink   (input valid, opcode, row_index, column_index, cell_on, distance,
                   output ready);
endinterface

[hw/rtl/bgac_rsp_if.sv]
// Response channel interface: one result word per handshake.
interface bgac_rsp_if
   import bgac_pkg::*;
   ;
   logic                        valid;
   logic                        ready;
   logic signed [SUM_OUT_W-1:0] correlation_sum;
   logic                        distance_error;

   modport source (output valid, correlation_sum, distance_error, input ready);
   modport sink   (input valid, correlation_sum, distance_error, output ready);
endinterface

[hw/rtl/binary_grid_autocorrelation_unit.sv]
// Top level of the binary grid autocorrelation unit.
// The unit keeps a grid of on/off cells and answers correlation queries over it. A write
// word sets one cell and the unit is ready again at once. A vertical query reads row 0
// and row d together, then compares 8 columns per cycle in the shared match counter. A
// horizontal query reads one row per cycle through read port A and checks columns 0
// and d. A query with a distance out of range goes straight to a zero result with the
// distance error set. The unit takes no new word while a query is in progress; a
// finished result waits in an output register.
// The grid is not cleared at reset, so a cell must be written before a query reads it.
`include "binary_grid_autocorrelation_unit_macros.svh"

module binary_grid_autocorrelation_unit
   import bgac_pkg::*;
#(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 256
) (
   input  logic              clock,
   input  logic              reset,
   bgac_req_if.sink          req_word,
   bgac_rsp_if.source        rsp_word,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int ROW_AW = $clog2(MAX_ROWS);
   localparam int COL_AW = $clog2(MAX_COLUMNS);
   localparam int H_W    = $clog2(MAX_ROWS + 1);
   localparam int W_W    = $clog2(MAX_COLUMNS + 1);
   localparam int CNT_W  = (H_W > W_W) ? H_W : W_W;
   localparam int NCHUNK = (MAX_COLUMNS + CHUNK_W - 1) / CHUNK_W;
   localparam int CK_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int PAD_W  = NCHUNK * CHUNK_W;
   localparam int STEP_W = (ROW_AW > CK_W) ? ROW_AW : CK_W;
   localparam int SUM_W  = CNT_W + 2;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_VLOAD  = 6'b000010,
      S_VSCAN  = 6'b000100,
      S_HSCAN  = 6'b001000,
      S_HDRAIN = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [STEP_W-1:0]  last_ff, last_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [ROW_AW-1:0]  dist_row_ff, dist_row_in;
   logic [COL_AW-1:0]  dist_col_ff, dist_col_in;
   logic               err_ff, err_in;
   logic               hpend_ff, hpend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_OUT_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic               rsp_err_ff, rsp_err_in;
   logic [HEIGHT_W-1:0] grid_height_ff, grid_height_in;
   logic [WIDTH_W-1:0]  grid_width_ff, grid_width_in;

   logic               req_fire;
   logic               rsp_load;
   logic [H_W-1:0]     h_use;
   logic [W_W-1:0]     w_use;
   logic [31:0]        dist32;
   logic [31:0]        row32;
   logic [31:0]        col32;
   logic               csr_write;
   logic               csr_index;

   logic               mem_wr_en;
   logic               mem_rd_en;
   logic [ROW_AW-1:0]  mem_rd_a_row;
   logic [MAX_COLUMNS-1:0] rd_a_data;
   logic [MAX_COLUMNS-1:0] rd_b_data;
   logic [PAD_W-1:0]   pad_a;
   logic [PAD_W-1:0]   pad_b;
   logic [CK_W-1:0]    chunk_idx;
   logic [CHUNK_W-1:0] agree;
   bgac_acc_ctrl_type  acc_ctrl;
   logic [CNT_W-1:0]   match_count;
   logic signed [SUM_W-1:0] diff;
   logic signed [31:0] diff32;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      grid_height_in = grid_height_ff;
      grid_width_in  = grid_width_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_GRID_HEIGHT: grid_height_in = csr_pwdata[HEIGHT_W-1:0];
            REG_GRID_WIDTH:  grid_width_in  = csr_pwdata[WIDTH_W-1:0];
            default:         grid_height_in = grid_height_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_GRID_HEIGHT: csr_prdata = CSR_DW'(grid_height_ff);
         REG_GRID_WIDTH:  csr_prdata = CSR_DW'(grid_width_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Height and width in use, limited to the storage.
   assign h_use = (32'(grid_height_ff) > MAX_ROWS) ? H_W'(MAX_ROWS) : H_W'(grid_height_ff);
   assign w_use = (32'(grid_width_ff) > MAX_COLUMNS) ? W_W'(MAX_COLUMNS)
                                                     : W_W'(grid_width_ff);

   // Request decode.
   assign req_word.ready = (state_ff == S_IDLE);
   assign req_fire = req_word.valid && req_word.ready;
   assign dist32   = 32'(req_word.distance);
   assign row32    = 32'(req_word.row_index);
   assign col32    = 32'(req_word.column_index);

   // Cell writes inside the storage go straight to the memory when accepted.
   assign mem_wr_en = req_fire && (req_word.opcode == OP_WRITE)
                      && (row32 < MAX_ROWS) && (col32 < MAX_COLUMNS);

   assign mem_rd_en    = (state_ff == S_VLOAD) || (state_ff == S_HSCAN);
   assign mem_rd_a_row = (state_ff == S_HSCAN) ? step_ff[ROW_AW-1:0] : '0;

   bgac_grid_mem #(
      .ROWS (MAX_ROWS),
      .COLS (MAX_COLUMNS)
   ) u_grid_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_row    (row32[ROW_AW-1:0]),
      .wr_col    (col32[COL_AW-1:0]),
      .wr_bit    (req_word.cell_on),
      .rd_en     (mem_rd_en),
      .rd_a_row  (mem_rd_a_row),
      .rd_b_row  (dist_row_ff),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // Agreement bits fed to the match counter: a column chunk or one row.
   assign pad_a     = PAD_W'(rd_a_data);
   assign pad_b     = PAD_W'(rd_b_data);
   assign chunk_idx = step_ff[CK_W-1:0];

   always_comb begin
      agree = '0;
      if (state_ff == S_VSCAN) begin
         for (int j = 0; j < CHUNK_W; j++) begin
            agree[j] = ~(pad_a[chunk_idx*CHUNK_W + j] ^ pad_b[chunk_idx*CHUNK_W + j])
                       && ((32'(chunk_idx) * CHUNK_W + j) < 32'(n_ff));
         end
      end else begin
         agree[0] = ~(rd_a_data[0] ^ rd_a_data[dist_col_ff]);
      end
   end

   bgac_match_unit #(
      .CNT_W (CNT_W)
   ) u_match_unit (
      .clock (clock),
      .ctrl  (acc_ctrl),
      .agree (agree),
      .count (match_count)
   );

   // Query sequencer.
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      last_in     = last_ff;
      n_in        = n_ff;
      dist_row_in = dist_row_ff;
      dist_col_in = dist_col_ff;
      err_in      = err_ff;
      hpend_in    = (state_ff == S_HSCAN);
      acc_ctrl.clear = 1'b0;
      acc_ctrl.add   = hpend_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               dist_row_in = dist32[ROW_AW-1:0];
               dist_col_in = dist32[COL_AW-1:0];
               step_in     = '0;
               unique case (req_word.opcode)
                  OP_VERT: begin
                     acc_ctrl.clear = 1'b1;
                     err_in  = (dist32 >= 32'(h_use));
                     n_in    = err_in ? '0 : CNT_W'(w_use);
                     last_in = STEP_W'((w_use - W_W'(1)) >> CHUNK_LOG);
                     state_in = (err_in || (w_use == '0)) ? S_DONE : S_VLOAD;
                  end
                  OP_HORZ: begin
                     acc_ctrl.clear = 1'b1;
                     err_in  = (dist32 >= 32'(w_use));
                     n_in    = err_in ? '0 : CNT_W'(h_use);
                     last_in = STEP_W'(h_use - H_W'(1));
                     state_in = (err_in || (h_use == '0)) ? S_DONE : S_HSCAN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_VLOAD: state_in = S_VSCAN;
         S_VSCAN: begin
            acc_ctrl.add = 1'b1;
            if (step_ff == last_ff) begin
               state_in = S_DONE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_HSCAN: begin
            if (step_ff == last_ff) begin
               state_in = S_HDRAIN;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_HDRAIN: state_in = S_DONE;
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sum = agreements - disagreements = 2 * matches - cells, then saturated.
   assign diff   = $signed({1'b0, match_count, 1'b0}) - $signed({2'b00, n_ff});
   assign diff32 = 32'(diff);

   always_comb begin
      if (err_ff) begin
         rsp_sum_in = '0;
      end else if (diff32 > SUM_MAX) begin
         rsp_sum_in = SUM_OUT_W'(SUM_MAX);
      end else if (diff32 < SUM_MIN) begin
         rsp_sum_in = SUM_OUT_W'(SUM_MIN);
      end else begin
         rsp_sum_in = diff32[SUM_OUT_W-1:0];
      end
   end

   // Output register.
   assign rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_word.ready);
   assign rsp_err_in   = err_ff;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_word.ready ? 1'b0 : rsp_valid_ff);

   assign rsp_word.valid           = rsp_valid_ff;
   assign rsp_word.correlation_sum = rsp_sum_ff;
   assign rsp_word.distance_error  = rsp_err_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         hpend_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         grid_height_ff <= HEIGHT_RESET;
         grid_width_ff  <= WIDTH_RESET;
      end else begin
         state_ff       <= state_in;
         hpend_ff       <= hpend_in;
         rsp_valid_ff   <= rsp_valid_in;
         grid_height_ff <= grid_height_in;
         grid_width_ff  <= grid_width_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      last_ff     <= last_in;
      n_ff        <= n_in;
      dist_row_ff <= dist_row_in;
      dist_col_ff <= dist_col_in;
      err_ff      <= err_in;
      if (rsp_load) begin
         rsp_sum_ff <= rsp_sum_in;
         rsp_err_ff <= rsp_err_in;
      end
   end

   // Checks on the sequencer and the result path.
   `BGAC_ASSERT_IMP(a_err_sum_zero, rsp_valid_ff && rsp_err_ff, rsp_sum_ff == '0)
   `BGAC_ASSERT_IMP(a_count_bound, state_ff == S_DONE, match_count <= n_ff)
   `BGAC_ASSERT_NXT(a_query_busy, req_fire && (req_word.opcode == OP_VERT || req_word.opcode == OP_HORZ), !req_word.ready)
   `BGAC_ASSERT_NXT(a_write_idle, req_fire && req_word.opcode == OP_WRITE, state_ff == S_IDLE)

endmodule

[hw/rtl/bgac_grid_mem.sv]
// Cell storage: one memory row per grid row, bit write, two registered row reads.
module bgac_grid_mem #(
   parameter int ROWS = 64,
   parameter int COLS = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(ROWS)-1:0]  wr_row,
   input  logic [$clog2(COLS)-1:0]  wr_col,
   input  logic                     wr_bit,
   input  logic                     rd_en,
   input  logic [$clog2(ROWS)-1:0]  rd_a_row,
   input  logic [$clog2(ROWS)-1:0]  rd_b_row,
   output logic [COLS-1:0]          rd_a_data,
   output logic [COLS-1:0]          rd_b_data
);

   logic [COLS-1:0] mem [ROWS];
   logic [COLS-1:0] rd_a_data_ff;
   logic [COLS-1:0] rd_b_data_ff;

   // Single cell write into its row.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row][wr_col] <= wr_bit;
      end
   end

   // Both read ports hold their data while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_data_ff <= mem[rd_a_row];
         rd_b_data_ff <= mem[rd_b_row];
      end
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

[hw/rtl/bgac_match_unit.sv]
// Shared match counter: adds the number of agreeing cells in one chunk per cycle while add is set.
module bgac_match_unit
   import bgac_pkg::*;
#(
   parameter int CNT_W = 9
) (
   input  logic              clock,
   input  bgac_acc_ctrl_type ctrl,
   input  logic [CHUNK_W-1:0] agree,
   output logic [CNT_W-1:0]  count
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] ones;

   // Population count of the agreement bits of this chunk.
   always_comb begin
      ones = '0;
      for (int j = 0; j < CHUNK_W; j++) begin
         ones = ones + CNT_W'(agree[j]);
      end
   end

   // Clear at the start of a query, accumulate on each valid chunk.
   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.add) begin
         count_in = count_ff + ones;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   assign count = count_ff;

endmodule
